/* rtl/jrd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrd_pkg
// Types and constants shared by the jump recording detector modules.
// ----------------------------------------------------------------------------
package jrd_pkg;

    localparam int unsigned AltW       = 18;
    localparam int unsigned CfgAltW    = 17;
    localparam int unsigned SpdW       = 12;
    localparam int unsigned CfgSpdW    = 11;
    localparam int unsigned TimeW      = 32;
    localparam int unsigned CfgIdxW    = 3;
    localparam int unsigned CfgDataW   = 32;
    localparam int unsigned InDataW    = 64;
    localparam int unsigned OutDataW   = 8;

    // register indexes
    localparam logic [CfgIdxW-1:0] RegStartAlt      = 3'd0;
    localparam logic [CfgIdxW-1:0] RegFreefallSpeed = 3'd1;
    localparam logic [CfgIdxW-1:0] RegMaxWaitMs     = 3'd2;
    localparam logic [CfgIdxW-1:0] RegStopAlt       = 3'd3;
    localparam logic [CfgIdxW-1:0] RegStillSpeed    = 3'd4;
    localparam logic [CfgIdxW-1:0] RegSettleMs      = 3'd5;

    typedef struct packed {
        logic [CfgAltW-1:0] start_alt;
        logic [CfgSpdW-1:0] freefall_speed;
        logic [TimeW-1:0]   max_wait_ms;
        logic [CfgAltW-1:0] stop_alt;
        logic [CfgSpdW-1:0] still_speed;
        logic [TimeW-1:0]   settle_ms;
    } cfg_t;

    typedef struct packed {
        logic signed [AltW-1:0] altitude;
        logic signed [SpdW-1:0] vert_speed;
        logic                   climb_mode;
        logic [TimeW-1:0]       now_ms;
    } item_t;

    typedef struct packed {
        logic                   rec_active;
        logic                   saw_freefall;
        logic                   saw_descent;
        logic signed [AltW-1:0] peak_alt;
        logic                   low_flag;
        logic [TimeW-1:0]       low_since;
        logic [TimeW-1:0]       started_at;
    } state_t;

    typedef struct packed {
        logic recording;
        logic finished;
        logic aborted;
    } result_t;

endpackage

`default_nettype wire

/* rtl/jrd_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrd_core
// Next-state and result logic for one altitude sample.
// ----------------------------------------------------------------------------
module jrd_core (
    input  wire jrd_pkg::cfg_t    cfg,
    input  wire jrd_pkg::state_t  cur,
    input  wire jrd_pkg::item_t   item,
    output jrd_pkg::state_t       nxt,
    output jrd_pkg::result_t      res
);
    import jrd_pkg::*;

    logic signed [AltW:0]   alt_x;
    logic signed [AltW:0]   start_x;
    logic signed [AltW:0]   stop_x;
    logic signed [AltW:0]   peak_x;
    logic signed [AltW:0]   margin_x;
    logic signed [SpdW+1:0] spd_x;
    logic signed [SpdW+1:0] desc_x;
    logic signed [SpdW+1:0] aspd_x;
    logic signed [SpdW+1:0] ff_x;
    logic signed [SpdW+1:0] still_x;
    logic signed [AltW-1:0] peak_new;
    logic                   falling;
    logic                   climbing;
    logic                   ff_new;
    logic                   low_still;
    logic [TimeW-1:0]       since_start;
    logic [TimeW-1:0]       since_low;

    always_comb begin
        alt_x    = {item.altitude[AltW-1], item.altitude};
        start_x  = $signed({2'b00, cfg.start_alt});
        stop_x   = $signed({2'b00, cfg.stop_alt});
        spd_x    = {{2{item.vert_speed[SpdW-1]}}, item.vert_speed};
        desc_x   = -spd_x;
        aspd_x   = spd_x[SpdW+1] ? desc_x : spd_x;
        ff_x     = $signed({3'b000, cfg.freefall_speed});
        still_x  = $signed({3'b000, cfg.still_speed});
        falling  = desc_x >= ff_x;
        climbing = item.climb_mode && (alt_x > start_x);

        ff_new   = cur.saw_freefall | falling;
        peak_new = (item.altitude > cur.peak_alt) ? item.altitude : cur.peak_alt;
        peak_x   = {peak_new[AltW-1], peak_new};
        margin_x = peak_x - start_x;
        low_still   = (alt_x < stop_x) && (aspd_x < still_x);
        since_start = item.now_ms - cur.started_at;
        since_low   = item.now_ms - cur.low_since;

        nxt = cur;
        res = '0;

        if (!cur.rec_active) begin
            if (climbing || falling) begin
                nxt.rec_active   = 1'b1;
                nxt.started_at   = item.now_ms;
                nxt.saw_freefall = falling;
                nxt.saw_descent  = falling;
                nxt.peak_alt     = item.altitude;
                nxt.low_flag     = 1'b0;
            end
        end else begin
            nxt.saw_freefall = ff_new;
            nxt.peak_alt     = peak_new;
            // no freefall within the wait window
            if (!ff_new && (since_start >= cfg.max_wait_ms)) begin
                nxt.rec_active = 1'b0;
                nxt.low_flag   = 1'b0;
                res.aborted    = 1'b1;
            end else begin
                if ((peak_x > start_x) && (alt_x < margin_x)) begin
                    nxt.saw_descent = 1'b1;
                end
                if (low_still) begin
                    if (!cur.low_flag) begin
                        nxt.low_flag  = 1'b1;
                        nxt.low_since = item.now_ms;
                    end else if (nxt.saw_descent && (since_low >= cfg.settle_ms)) begin
                        nxt.rec_active = 1'b0;
                        nxt.low_flag   = 1'b0;
                        res.finished   = ff_new;
                        res.aborted    = ~ff_new;
                    end
                end else begin
                    nxt.low_flag = 1'b0;
                end
            end
        end
        res.recording = nxt.rec_active;
    end

endmodule

`default_nettype wire

/* rtl/jump_recording_detector.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jump_recording_detector
// Decides when a skydive recording starts and stops from altitude samples.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_*       in         one sample request: altitude, speed, climb flag, time
//  m_*       out        one result per sample: recording, finished, aborted
//  cfg_*     in         register write, index and data
//
//  one sample per cycle sustained while m_tready is high; a result is registered
//  after accept (input register, then result register around the compare logic)
//  the tracking state updates when a sample moves into the result register
//  a stalled result holds while the input register still takes one sample
//  aresetn clears the valid flags, tracking state and configuration registers
module jump_recording_detector (
    input  wire                          aclk,
    input  wire                          aresetn,
    // altitude[17:0], vert_speed[29:18], climb_mode[30], now_ms[62:31]
    input  wire [jrd_pkg::InDataW-1:0]   s_tdata,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // recording[0], finished[1], aborted[2]
    output logic [jrd_pkg::OutDataW-1:0] m_tdata,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    input  wire                          cfg_wr_en,
    input  wire [jrd_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire [jrd_pkg::CfgDataW-1:0]  cfg_data
);
    import jrd_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                RegStartAlt:      cfg_reg.start_alt      <= cfg_data[CfgAltW-1:0];
                RegFreefallSpeed: cfg_reg.freefall_speed <= cfg_data[CfgSpdW-1:0];
                RegMaxWaitMs:     cfg_reg.max_wait_ms    <= cfg_data[TimeW-1:0];
                RegStopAlt:       cfg_reg.stop_alt       <= cfg_data[CfgAltW-1:0];
                RegStillSpeed:    cfg_reg.still_speed    <= cfg_data[CfgSpdW-1:0];
                RegSettleMs:      cfg_reg.settle_ms      <= cfg_data[TimeW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.altitude   <= s_tdata[17:0];
            item_reg.vert_speed <= s_tdata[29:18];
            item_reg.climb_mode <= s_tdata[30];
            item_reg.now_ms     <= s_tdata[62:31];
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    jrd_core u_core (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, res_reg.aborted, res_reg.finished, res_reg.recording};

endmodule

`default_nettype wire

/* rtl/jrd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrd_checker
// Port-level checks for the jump recording detector.
// ----------------------------------------------------------------------------
module jrd_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire [jrd_pkg::OutDataW-1:0]  m_tdata,
    input wire                          m_tvalid,
    input wire                          m_tready
);
    import jrd_pkg::*;

    // a recording ends one way only
    a_end_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
        else $error("finished and aborted together");

    // an ending sample leaves recording off
    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1] || m_tdata[2])) |-> !m_tdata[0])
        else $error("recording still set on ending sample");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result dropped or changed");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind jump_recording_detector jrd_checker u_jrd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
